/* rtl/mpe_pkg.sv */
// Package for the multiset permutation enumerator.
// Holds field widths, constants, the controller state type and the
// command and status structs. Depends on nothing.
package mpe_pkg;

    localparam int unsigned NumLetters          = 4;
    localparam int unsigned LetterWidth         = 5;
    localparam int unsigned AsciiWidth          = 7;
    localparam int unsigned CountWidth          = 5;
    localparam int unsigned AlphabetSizeDefault = 26;
    localparam int unsigned MaxOrders           = 24;

    // Letter index 1 maps to ASCII 'A', so the offset is 'A' - 1.
    localparam logic [AsciiWidth-1:0] LetterOffset = 7'd64;

    typedef logic [LetterWidth-1:0] t_letter;
    typedef logic [AsciiWidth-1:0]  t_ascii;
    typedef logic [CountWidth-1:0]  t_count;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture and sort a new multiset
        logic advance;  // step to the next ordering
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;     // the held ordering is the final one
    } t_dp_status;

endpackage

/* rtl/mpe_if.sv */
// Valid/ready channel interfaces for the multiset permutation enumerator.
// Input channel carries four letter indices; output channel one ordering.
// Depends on mpe_pkg.
interface mpe_in_if;
    logic                 valid;
    logic                 ready;
    mpe_pkg::t_letter     letter_0;
    mpe_pkg::t_letter     letter_1;
    mpe_pkg::t_letter     letter_2;
    mpe_pkg::t_letter     letter_3;

    modport source (output valid, letter_0, letter_1, letter_2, letter_3, input ready);
    modport sink   (input valid, letter_0, letter_1, letter_2, letter_3, output ready);
endinterface

interface mpe_out_if;
    logic                 valid;
    logic                 ready;
    mpe_pkg::t_ascii      out_letter_0;
    mpe_pkg::t_ascii      out_letter_1;
    mpe_pkg::t_ascii      out_letter_2;
    mpe_pkg::t_ascii      out_letter_3;
    mpe_pkg::t_count      perm_number;
    logic                 is_last;

    modport source (output valid, out_letter_0, out_letter_1, out_letter_2, out_letter_3,
                    perm_number, is_last, input ready);
    modport sink   (input valid, out_letter_0, out_letter_1, out_letter_2, out_letter_3,
                    perm_number, is_last, output ready);
endinterface

/* rtl/mpe_datapath.sv */
// Datapath of the multiset permutation enumerator: clamp, sort, ordering
// register, next-ordering logic and running count.
// Depends on mpe_pkg.
module mpe_datapath #(
    parameter int unsigned ALPHABET_SIZE = mpe_pkg::AlphabetSizeDefault
) (
    input  logic                i_clk,
    input  mpe_pkg::t_dp_cmd    i_cmd,
    input  mpe_pkg::t_letter    i_letter_0,
    input  mpe_pkg::t_letter    i_letter_1,
    input  mpe_pkg::t_letter    i_letter_2,
    input  mpe_pkg::t_letter    i_letter_3,
    output mpe_pkg::t_dp_status o_status,
    output mpe_pkg::t_ascii     o_out_letter_0,
    output mpe_pkg::t_ascii     o_out_letter_1,
    output mpe_pkg::t_ascii     o_out_letter_2,
    output mpe_pkg::t_ascii     o_out_letter_3,
    output mpe_pkg::t_count     o_perm_number
);
    import mpe_pkg::*;

    localparam t_letter MaxLetter = t_letter'(ALPHABET_SIZE);

    t_letter r_order [0:NumLetters-1];
    t_letter n_order [0:NumLetters-1];
    t_count  r_count;
    t_count  n_count;

    t_letter clamped [0:NumLetters-1];
    t_letter s1      [0:NumLetters-1];
    t_letter s2      [0:NumLetters-1];
    t_letter sorted  [0:NumLetters-1];
    t_letter nxt     [0:NumLetters-1];
    logic    has_next;

    function automatic t_letter clamp_letter(input t_letter v);
        t_letter r;
        if (v == '0) begin
            r = t_letter'(1);
        end else if (v > MaxLetter) begin
            r = MaxLetter;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Clamp, then a five-comparator sorting network in three levels.
    always_comb begin
        clamped[0] = clamp_letter(i_letter_0);
        clamped[1] = clamp_letter(i_letter_1);
        clamped[2] = clamp_letter(i_letter_2);
        clamped[3] = clamp_letter(i_letter_3);

        s1[0] = (clamped[0] < clamped[1]) ? clamped[0] : clamped[1];
        s1[1] = (clamped[0] < clamped[1]) ? clamped[1] : clamped[0];
        s1[2] = (clamped[2] < clamped[3]) ? clamped[2] : clamped[3];
        s1[3] = (clamped[2] < clamped[3]) ? clamped[3] : clamped[2];

        s2[0] = (s1[0] < s1[2]) ? s1[0] : s1[2];
        s2[2] = (s1[0] < s1[2]) ? s1[2] : s1[0];
        s2[1] = (s1[1] < s1[3]) ? s1[1] : s1[3];
        s2[3] = (s1[1] < s1[3]) ? s1[3] : s1[1];

        sorted[0] = s2[0];
        sorted[1] = (s2[1] < s2[2]) ? s2[1] : s2[2];
        sorted[2] = (s2[1] < s2[2]) ? s2[2] : s2[1];
        sorted[3] = s2[3];
    end

    // Next lexicographic ordering, written out for each possible pivot.
    always_comb begin
        for (int k = 0; k < NumLetters; k++) begin
            nxt[k] = r_order[k];
        end
        has_next = 1'b1;
        if (r_order[2] < r_order[3]) begin
            nxt[2] = r_order[3];
            nxt[3] = r_order[2];
        end else if (r_order[1] < r_order[2]) begin
            if (r_order[3] > r_order[1]) begin
                nxt[1] = r_order[3];
                nxt[2] = r_order[1];
                nxt[3] = r_order[2];
            end else begin
                nxt[1] = r_order[2];
                nxt[2] = r_order[3];
                nxt[3] = r_order[1];
            end
        end else if (r_order[0] < r_order[1]) begin
            if (r_order[3] > r_order[0]) begin
                nxt[0] = r_order[3];
                nxt[1] = r_order[0];
                nxt[2] = r_order[2];
                nxt[3] = r_order[1];
            end else if (r_order[2] > r_order[0]) begin
                nxt[0] = r_order[2];
                nxt[1] = r_order[3];
                nxt[2] = r_order[0];
                nxt[3] = r_order[1];
            end else begin
                nxt[0] = r_order[1];
                nxt[1] = r_order[3];
                nxt[2] = r_order[2];
                nxt[3] = r_order[0];
            end
        end else begin
            has_next = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < NumLetters; k++) begin
            n_order[k] = r_order[k];
        end
        n_count = r_count;
        if (i_cmd.load) begin
            for (int k = 0; k < NumLetters; k++) begin
                n_order[k] = sorted[k];
            end
            n_count = t_count'(1);
        end else if (i_cmd.advance) begin
            for (int k = 0; k < NumLetters; k++) begin
                n_order[k] = nxt[k];
            end
            n_count = r_count + t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NumLetters; k++) begin
            r_order[k] <= n_order[k];
        end
        r_count <= n_count;
    end

    assign o_status.last  = ~has_next || (r_count >= t_count'(MaxOrders));
    assign o_out_letter_0 = {2'b00, r_order[0]} + LetterOffset;
    assign o_out_letter_1 = {2'b00, r_order[1]} + LetterOffset;
    assign o_out_letter_2 = {2'b00, r_order[2]} + LetterOffset;
    assign o_out_letter_3 = {2'b00, r_order[3]} + LetterOffset;
    assign o_perm_number  = r_count;

endmodule

/* rtl/mpe_controller.sv */
// Controller of the multiset permutation enumerator: a two-state machine
// that loads a multiset and then steps through its orderings.
// Depends on mpe_pkg.
module mpe_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  mpe_pkg::t_dp_status i_status,
    output mpe_pkg::t_dp_cmd    o_cmd
);
    import mpe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.advance = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/multiset_permutation_enumerator_top.sv */
// Top level of the multiset permutation enumerator.
// Joins mpe_controller and mpe_datapath to the channel interfaces.
// Depends on mpe_pkg, mpe_if, mpe_controller and mpe_datapath.

// The block takes a multiset of four letters (indices 1 for A up to
// ALPHABET_SIZE, in any order) in one input transfer and returns every
// distinct ordering of them in ascending lexicographic order, one ordering
// per output transfer, with a running number from 1 and a flag on the last
// one. Index zero is treated as A and an index above ALPHABET_SIZE as the
// last letter. A multiset with four different letters yields 24 results;
// repeated letters yield fewer, down to one for four equal letters. In the
// input transfer the letters are clamped, sorted and captured; after that
// the ordering register moves to the next ordering in the cycle each result
// is taken. The next-ordering logic works on the single ordering register,
// so the block holds one multiset at a time: input ready is high only while
// no result is pending, and a new multiset is taken in the cycle after the
// last result transfers. Results come straight from the ordering and count
// registers, and they hold steady while the sink stalls.
module multiset_permutation_enumerator_top #(
    parameter int unsigned ALPHABET_SIZE = mpe_pkg::AlphabetSizeDefault
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mpe_in_if.sink    i_in,
    mpe_out_if.source o_out
);
    import mpe_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // The controller owns both handshakes and issues load and advance.
    mpe_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the current ordering and its running number.
    mpe_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_letter_0     (i_in.letter_0),
        .i_letter_1     (i_in.letter_1),
        .i_letter_2     (i_in.letter_2),
        .i_letter_3     (i_in.letter_3),
        .o_status       (status),
        .o_out_letter_0 (o_out.out_letter_0),
        .o_out_letter_1 (o_out.out_letter_1),
        .o_out_letter_2 (o_out.out_letter_2),
        .o_out_letter_3 (o_out.out_letter_3),
        .o_perm_number  (o_out.perm_number)
    );

    assign o_out.is_last = status.last;

    // A new multiset is never taken while a result is still offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a result is pending");

    // The first result after an input transfer is numbered one.
    a_first_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (o_out.valid && o_out.perm_number == t_count'(1)))
        else $error("first result missing or misnumbered");

    // A result that is not the last is followed by the next number.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.is_last) |=>
        (o_out.valid && o_out.perm_number == $past(o_out.perm_number) + t_count'(1)))
        else $error("running number did not advance by one");

    // The number of orderings never exceeds the count for four distinct letters.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.perm_number <= t_count'(MaxOrders)))
        else $error("running number beyond the maximum");

endmodule

/* sim/multiset_permutation_enumerator_top_tb.sv */
// Self-checking testbench for multiset_permutation_enumerator_top.
// Drives multisets through mpe_in_if and checks every ordering on mpe_out_if
// against a local predictor. Depends on mpe_pkg, mpe_if and the top level.
`timescale 1ns / 100ps

module multiset_permutation_enumerator_top_tb;

    import mpe_pkg::*;

    // The block is built with its default alphabet.
    localparam int unsigned AlphaSize   = AlphabetSizeDefault;
    localparam int unsigned MaxGap      = 17;
    localparam int unsigned RandomBlocks = 14;
    localparam int unsigned BlockItems  = 20;
    localparam int unsigned HoldCycles  = 300;

    // One expected ordering, with the same fields as an output transfer.
    typedef struct packed {
        t_ascii letter_0;
        t_ascii letter_1;
        t_ascii letter_2;
        t_ascii letter_3;
        t_count number;
        logic   last;
    } t_ordering;

    logic clk = 1'b0;
    logic rst_n;

    mpe_in_if  in_ch ();
    mpe_out_if out_ch ();

    // Orderings that the block still owes, oldest first.
    t_ordering   pending_orderings[$];
    int unsigned mismatch_count = 0;

    // Idling controls. When an idle flag is clear that side runs at full rate.
    // A nonzero hold request makes the receiver keep ready low for that many
    // cycles once, at the start of its next turn.
    bit          tx_idle_on  = 1'b0;
    bit          rx_idle_on  = 1'b0;
    int unsigned rx_hold_req = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    multiset_permutation_enumerator_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Index zero reads as A and anything past the alphabet as its last letter.
    function automatic int unsigned saturate_index(input t_letter raw);
        if (raw == '0) begin
            return 1;
        end
        if (32'(raw) > AlphaSize) begin
            return AlphaSize;
        end
        return 32'(raw);
    endfunction

    // Works out every distinct ordering of one multiset, in ascending
    // lexicographic order, and queues them as expectations.
    function automatic void enumerate_orderings(input t_letter l0, input t_letter l1,
                                                input t_letter l2, input t_letter l3);
        int unsigned v[4];
        int unsigned tmp;
        int          i;
        int          j;
        int          lo;
        int          hi;
        int unsigned count = 0;
        bit          more  = 1'b1;
        t_ordering   o;
        v[0] = saturate_index(l0);
        v[1] = saturate_index(l1);
        v[2] = saturate_index(l2);
        v[3] = saturate_index(l3);
        // Start from the smallest ordering.
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3 - i; j++) begin
                if (v[j] > v[j+1]) begin
                    tmp    = v[j];
                    v[j]   = v[j+1];
                    v[j+1] = tmp;
                end
            end
        end
        while (more) begin
            count++;
            o.letter_0 = t_ascii'(LetterOffset + v[0]);
            o.letter_1 = t_ascii'(LetterOffset + v[1]);
            o.letter_2 = t_ascii'(LetterOffset + v[2]);
            o.letter_3 = t_ascii'(LetterOffset + v[3]);
            o.number   = t_count'(count);
            // Step to the next ordering: find the rightmost rise, swap it with
            // the smallest larger letter to its right, then reverse the tail.
            // Equal letters never count as a rise, so repeats are skipped.
            more = 1'b0;
            if (count < MaxOrders) begin
                i = 2;
                while (i >= 0 && v[i] >= v[i+1]) begin
                    i--;
                end
                if (i >= 0) begin
                    j = 3;
                    while (v[j] <= v[i]) begin
                        j--;
                    end
                    tmp  = v[i];
                    v[i] = v[j];
                    v[j] = tmp;
                    lo = i + 1;
                    hi = 3;
                    while (lo < hi) begin
                        tmp   = v[lo];
                        v[lo] = v[hi];
                        v[hi] = tmp;
                        lo++;
                        hi--;
                    end
                    more = 1'b1;
                end
            end
            o.last = !more;
            pending_orderings.push_back(o);
        end
    endfunction

    // Offers one multiset and returns at the falling edge after its transfer.
    // Valid stays high on return so that back-to-back items need no gap;
    // whoever idles the channel lowers it.
    task automatic send_multiset(input t_letter l0, input t_letter l1,
                                 input t_letter l2, input t_letter l3);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, MaxGap) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.letter_0 <= l0;
        in_ch.letter_1 <= l1;
        in_ch.letter_2 <= l2;
        in_ch.letter_3 <= l3;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        enumerate_orderings(l0, l1, l2, l3);
        @(negedge clk);
    endtask

    // Idles the input and waits until every queued ordering has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_orderings.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // Most random multisets are drawn from a small pool of letters so that
    // every pattern of repeats turns up; the rest are raw 5-bit values that
    // exercise the saturation at both ends.
    task automatic send_random_multiset();
        int unsigned pool[4];
        int unsigned kinds;
        t_letter     f[4];
        if ($urandom_range(0, 9) < 8) begin
            kinds = $urandom_range(1, 4);
            for (int k = 0; k < 4; k++) begin
                pool[k] = $urandom_range(1, AlphaSize);
            end
            for (int k = 0; k < 4; k++) begin
                f[k] = t_letter'(pool[$urandom_range(0, kinds - 1)]);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                f[k] = t_letter'($urandom_range(0, 31));
            end
        end
        send_multiset(f[0], f[1], f[2], f[3]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver and checker. Every output transfer is compared with the oldest
    // expectation; a transfer with nothing expected is a failure too.
    initial begin : receive_orderings
        int unsigned stall;
        t_ordering   want;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, MaxGap) : 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) begin
                @(posedge clk);
            end
            if (pending_orderings.size() == 0) begin
                $display("%0t: unexpected ordering %c%c%c%c number %0d last %0b", $time,
                         out_ch.out_letter_0, out_ch.out_letter_1, out_ch.out_letter_2,
                         out_ch.out_letter_3, out_ch.perm_number, out_ch.is_last);
                mismatch_count++;
            end else begin
                want = pending_orderings.pop_front();
                check_field("out_letter_0", 8'(want.letter_0), 8'(out_ch.out_letter_0));
                check_field("out_letter_1", 8'(want.letter_1), 8'(out_ch.out_letter_1));
                check_field("out_letter_2", 8'(want.letter_2), 8'(out_ch.out_letter_2));
                check_field("out_letter_3", 8'(want.letter_3), 8'(out_ch.out_letter_3));
                check_field("perm_number", 8'(want.number), 8'(out_ch.perm_number));
                check_field("is_last", 8'(want.last), 8'(out_ch.is_last));
            end
            @(negedge clk);
        end
    end

    // Edge cases at full rate on the input and with random stalls at the
    // output: every count of repeats, both ends of the alphabet, and indices
    // that need saturating.
    task automatic test_directed();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        send_multiset(5'd1, 5'd1, 5'd1, 5'd1);      // four equal, lowest letter
        send_multiset(5'd26, 5'd26, 5'd26, 5'd26);  // four equal, highest letter
        send_multiset(5'd26, 5'd25, 5'd24, 5'd23);  // four different, reversed
        send_multiset(5'd1, 5'd2, 5'd3, 5'd4);      // four different, sorted
        send_multiset(5'd7, 5'd3, 5'd7, 5'd3);      // two pairs
        send_multiset(5'd9, 5'd9, 5'd2, 5'd9);      // three equal and one
        send_multiset(5'd4, 5'd12, 5'd4, 5'd20);    // one pair and two singles
        send_multiset(5'd0, 5'd0, 5'd0, 5'd0);      // index zero saturates to A
        send_multiset(5'd31, 5'd31, 5'd31, 5'd31);  // all ones saturates to Z
        send_multiset(5'd0, 5'd31, 5'd1, 5'd26);    // saturation forms two pairs
        send_multiset(5'd27, 5'd0, 5'd16, 5'd15);   // just past Z, bit four alone
        send_multiset(5'd21, 5'd10, 5'd5, 5'd31);   // alternating bit patterns
        send_multiset(5'd2, 5'd1, 5'd2, 5'd1);      // lowest two letters, paired
    endtask

    // Random multisets in blocks, each block with its own idling on either
    // side. The first block runs both sides at full rate.
    task automatic test_random();
        for (int unsigned blk = 0; blk < RandomBlocks; blk++) begin
            tx_idle_on = (blk != 0) && ($urandom_range(0, 2) != 0);
            rx_idle_on = (blk != 0) && ($urandom_range(0, 2) != 0);
            for (int unsigned n = 0; n < BlockItems; n++) begin
                send_random_multiset();
            end
        end
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // multisets at full rate, so the output stalls and input ready drops.
    task automatic test_backpressure();
        wait_drained();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = HoldCycles;
        send_multiset(5'd8, 5'd6, 5'd4, 5'd2);
        for (int n = 0; n < 5; n++) begin
            send_random_multiset();
        end
    endtask

    // The sender waits for every result before offering the next multiset.
    task automatic test_drain_pause();
        rx_idle_on = 1'b1;
        for (int n = 0; n < 4; n++) begin
            wait_drained();
            if (n == 0) begin
                send_multiset(5'd19, 5'd11, 5'd3, 5'd24);
            end else begin
                send_random_multiset();
            end
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.letter_0 = '0;
        in_ch.letter_1 = '0;
        in_ch.letter_2 = '0;
        in_ch.letter_3 = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random();
        test_backpressure();
        test_drain_pause();

        // All stimulus is in. Wait for the last orderings, then let the block
        // run on idle to show any stray transfer.
        wait_drained();
        repeat (50) @(posedge clk);

        if (mismatch_count == 0 && pending_orderings.size() == 0) begin
            $display("multiset_permutation_enumerator_top: match");
        end else begin
            $display("multiset_permutation_enumerator_top: mismatch");
        end
        $finish;
    end

    // A correct run needs well under a fifth of this, even with every item
    // yielding 24 orderings and every ordering waiting out the longest stall.
    initial begin
        #2000000;
        $display("multiset_permutation_enumerator_top: mismatch");
        $finish;
    end

endmodule
